// File: design/xss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xss_pkg;

    // Longest string body held before the scan stops with an error.
    localparam int unsigned MAX_STRING_BYTES = 2560;
    localparam int unsigned STR_LEN_W        = $clog2(MAX_STRING_BYTES + 1);

    localparam int unsigned ROW_W   = 17;
    localparam int unsigned FIELD_W = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FIELD_W-1:0] SAT_VALUE = '1;

    localparam logic [7:0] CHR_SLASH  = 8'h2F;
    localparam logic [7:0] CHR_STAR   = 8'h2A;
    localparam logic [7:0] CHR_LBRACE = 8'h7B;
    localparam logic [7:0] CHR_RBRACE = 8'h7D;
    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;

    typedef enum logic [2:0] {
        KIND_ROW_BYTE  = 3'd0,
        KIND_ROW_END   = 3'd1,
        KIND_HEADER    = 3'd2,
        KIND_BRACE_END = 3'd3,
        KIND_EARLY_END = 3'd4,
        KIND_TOO_LONG  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        SEC_PRE    = 3'd0,
        SEC_VALUES = 3'd1,
        SEC_ROWS   = 3'd2,
        SEC_EXTRA  = 3'd4,
        SEC_DONE   = 3'd5
    } section_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         row_byte;
        logic [ROW_W-1:0]   row_number;
        logic [FIELD_W-1:0] image_width;
        logic [FIELD_W-1:0] image_height;
        logic [FIELD_W-1:0] color_count;
        logic [FIELD_W-1:0] chars_per_pixel;
    } result_t;

    // Up to two result words made by one source byte, already compacted.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

`default_nettype wire

// File: design/xss_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module xss_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output xss_pkg::push_t     push
);

    logic                              comment_reg, comment_next;
    logic                              quote_reg, quote_next;
    logic                              slash_reg, slash_next;
    logic                              star_reg, star_next;
    xss_pkg::section_t                 section_reg, section_next;
    logic [xss_pkg::ROW_W-1:0]         rows_reg, rows_next;
    logic [xss_pkg::FIELD_W-1:0]       hf_reg [4];
    logic [xss_pkg::FIELD_W-1:0]       hf_next [4];
    logic [xss_pkg::FIELD_W-1:0]       acc_reg, acc_next;
    logic [2:0]                        fp_reg, fp_next;
    logic [xss_pkg::STR_LEN_W-1:0]     len_reg, len_next;
    logic                              stored_reg, stored_next;
    logic                              finished_reg, finished_next;
    logic                              digit_reg, digit_next;

    logic                              c_open, c_close, consumed, comment_now;
    logic                              close_write;
    logic [2:0]                        fp_closed;
    logic [19:0]                       acc_grown;
    logic [xss_pkg::ROW_W-1:0]         row_limit;
    logic                              main_v, eoi_v;
    xss_pkg::result_t                  main_res, eoi_res;

    assign c_open   = slash_reg && (in_byte == xss_pkg::CHR_STAR) && !comment_reg;
    assign c_close  = !c_open && star_reg && (in_byte == xss_pkg::CHR_SLASH) && comment_reg;
    assign consumed = c_open || c_close;
    assign comment_now = c_open ? 1'b1 : (c_close ? 1'b0 : comment_reg);

    // Closing a number stores it only when digits were seen and a slot is free.
    assign close_write = digit_reg && (fp_reg < 3'd4);
    assign fp_closed   = fp_reg + {2'b00, close_write};

    // acc * 10 + digit, saturated to 16 bits below.
    assign acc_grown = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + {16'd0, in_byte[3:0] - xss_pkg::CHR_ZERO[3:0]};

    assign row_limit = {1'b0, hf_reg[2]} + {1'b0, hf_reg[1]} + 17'd1;

    always_comb
    begin
        comment_next  = comment_reg;
        quote_next    = quote_reg;
        slash_next    = slash_reg;
        star_next     = star_reg;
        section_next  = section_reg;
        rows_next     = rows_reg;
        hf_next       = hf_reg;
        acc_next      = acc_reg;
        fp_next       = fp_reg;
        len_next      = len_reg;
        stored_next   = stored_reg;
        finished_next = finished_reg;
        digit_next    = digit_reg;
        main_v        = 1'b0;
        main_res      = '0;
        eoi_v         = 1'b0;
        eoi_res       = '0;

        if (in_valid && !finished_reg)
        begin
            comment_next = comment_now;
            slash_next   = !consumed && (in_byte == xss_pkg::CHR_SLASH) && !comment_now;
            star_next    = !consumed && (in_byte == xss_pkg::CHR_STAR) && comment_now;

            if (quote_reg)
            begin
                if ((in_byte == xss_pkg::CHR_QUOTE) && !comment_now)
                begin
                    quote_next = 1'b0;
                    if (len_reg != '0)
                    begin
                        if (section_reg == xss_pkg::SEC_VALUES)
                        begin
                            if (close_write)
                            begin
                                hf_next[fp_reg[1:0]] = acc_reg;
                            end
                            fp_next    = fp_closed;
                            acc_next   = '0;
                            digit_next = 1'b0;
                            if (fp_closed >= 3'd4)
                            begin
                                main_v                   = 1'b1;
                                main_res.kind            = xss_pkg::KIND_HEADER;
                                main_res.image_width     = hf_next[0];
                                main_res.image_height    = hf_next[1];
                                main_res.color_count     = hf_next[2];
                                main_res.chars_per_pixel = hf_next[3];
                                rows_next    = 17'd1;
                                section_next = xss_pkg::SEC_ROWS;
                            end
                        end
                        else if (section_reg == xss_pkg::SEC_ROWS)
                        begin
                            if (stored_reg)
                            begin
                                main_v              = 1'b1;
                                main_res.kind       = xss_pkg::KIND_ROW_END;
                                main_res.row_number = rows_reg;
                                rows_next           = rows_reg + 17'd1;
                            end
                            else
                            begin
                                section_next = xss_pkg::SEC_EXTRA;
                            end
                        end
                    end
                end
                else if (len_reg >= xss_pkg::STR_LEN_W'(xss_pkg::MAX_STRING_BYTES))
                begin
                    main_v              = 1'b1;
                    main_res.kind       = xss_pkg::KIND_TOO_LONG;
                    main_res.row_number = rows_reg;
                    finished_next       = 1'b1;
                    section_next        = xss_pkg::SEC_DONE;
                end
                else
                begin
                    len_next = len_reg + 1'b1;
                    if (section_reg == xss_pkg::SEC_VALUES)
                    begin
                        if (in_byte inside {[xss_pkg::CHR_ZERO:xss_pkg::CHR_NINE]})
                        begin
                            acc_next   = (acc_grown > {4'd0, xss_pkg::SAT_VALUE})
                                       ? xss_pkg::SAT_VALUE : acc_grown[15:0];
                            digit_next = 1'b1;
                        end
                        else
                        begin
                            if (close_write)
                            begin
                                hf_next[fp_reg[1:0]] = acc_reg;
                            end
                            fp_next    = fp_closed;
                            acc_next   = '0;
                            digit_next = 1'b0;
                        end
                    end
                    else if (section_reg == xss_pkg::SEC_ROWS)
                    begin
                        if (rows_reg < row_limit)
                        begin
                            main_v              = 1'b1;
                            main_res.kind       = xss_pkg::KIND_ROW_BYTE;
                            main_res.row_byte   = in_byte;
                            main_res.row_number = rows_reg;
                            stored_next         = 1'b1;
                        end
                    end
                end
            end
            else if (!consumed && !comment_now)
            begin
                if (in_byte == xss_pkg::CHR_QUOTE)
                begin
                    quote_next  = 1'b1;
                    len_next    = '0;
                    stored_next = 1'b0;
                    fp_next     = '0;
                    acc_next    = '0;
                    digit_next  = 1'b0;
                end
                else if ((in_byte == xss_pkg::CHR_LBRACE) && (section_reg == xss_pkg::SEC_PRE))
                begin
                    section_next = xss_pkg::SEC_VALUES;
                end
                else if (in_byte == xss_pkg::CHR_RBRACE)
                begin
                    main_v              = 1'b1;
                    main_res.kind       = xss_pkg::KIND_BRACE_END;
                    main_res.row_number = rows_reg;
                    finished_next       = 1'b1;
                    section_next        = xss_pkg::SEC_DONE;
                end
            end

            // The last byte of the file closes the scan if nothing else did.
            if (in_last && !finished_next)
            begin
                eoi_v              = 1'b1;
                eoi_res.kind       = xss_pkg::KIND_EARLY_END;
                eoi_res.row_number = rows_next;
                finished_next      = 1'b1;
            end
        end
    end

    assign push.count = {1'b0, main_v} + {1'b0, eoi_v};
    assign push.res0  = main_v ? main_res : eoi_res;
    assign push.res1  = eoi_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comment_reg  <= 1'b0;
            quote_reg    <= 1'b0;
            slash_reg    <= 1'b0;
            star_reg     <= 1'b0;
            section_reg  <= xss_pkg::SEC_PRE;
            rows_reg     <= '0;
            hf_reg       <= '{default: '0};
            acc_reg      <= '0;
            fp_reg       <= '0;
            len_reg      <= '0;
            stored_reg   <= 1'b0;
            finished_reg <= 1'b0;
            digit_reg    <= 1'b0;
        end
        else
        begin
            comment_reg  <= comment_next;
            quote_reg    <= quote_next;
            slash_reg    <= slash_next;
            star_reg     <= star_next;
            section_reg  <= section_next;
            rows_reg     <= rows_next;
            hf_reg       <= hf_next;
            acc_reg      <= acc_next;
            fp_reg       <= fp_next;
            len_reg      <= len_next;
            stored_reg   <= stored_next;
            finished_reg <= finished_next;
            digit_reg    <= digit_next;
        end
    end

    // Once the scan has ended no byte may produce a word.
    a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> (push.count == 2'd0))
        else $error("word produced after the scan ended");

    // A header word always moves the scan into the row section at row one.
    a_header_enters_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0 && push.res0.kind == xss_pkg::KIND_HEADER)
        |=> (section_reg == xss_pkg::SEC_ROWS && rows_reg == 17'd1))
        else $error("header word without entering the row section");

    // Scanner state only moves on an accepted byte.
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid |=> ($stable(rows_reg) && $stable(section_reg) && $stable(quote_reg)))
        else $error("scanner state changed without an input word");

endmodule

`default_nettype wire

// File: design/xss_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module xss_out_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire xss_pkg::push_t push,
    output logic               room,
    output logic               head_valid,
    input  wire logic          head_ready,
    output xss_pkg::result_t   head
);

    xss_pkg::result_t              mem_reg [xss_pkg::QUEUE_DEPTH];
    logic [xss_pkg::QPTR_W-1:0]    wr_reg, wr_next;
    logic [xss_pkg::QPTR_W-1:0]    rd_reg, rd_next;
    logic [xss_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                          pop;
    logic [xss_pkg::QPTR_W-1:0]    wr_second;

    assign pop        = head_valid && head_ready;
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_reg];
    // A byte may bring two words, so keep two places free before taking one.
    assign room       = (count_reg <= xss_pkg::QCNT_W'(xss_pkg::QUEUE_DEPTH - 2));
    assign wr_second  = wr_reg + 1'b1;

    assign wr_next    = wr_reg + xss_pkg::QPTR_W'(push.count);
    assign rd_next    = rd_reg + xss_pkg::QPTR_W'(pop);
    assign count_next = count_reg + xss_pkg::QCNT_W'(push.count)
                      - xss_pkg::QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_reg] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_second] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("words pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= xss_pkg::QCNT_W'(xss_pkg::QUEUE_DEPTH))
        else $error("queue fill beyond its depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg) + xss_pkg::QCNT_W'($past(push.count))
                  - xss_pkg::QCNT_W'($past(pop))))
        else $error("queue fill does not follow pushes and pops");

endmodule

`default_nettype wire

// File: design/xpm_source_scanner.sv
// Result words made by an accepted source byte are registered in the result queue and
// leave it in order; a second word from the same byte follows the first on the output.
// Throughput: one source byte per cycle while the output side takes words; s_tready drops
// only when the four-word result queue has fewer than two free places.
// Reset (rst_n, asynchronous, active low) clears the scanner state and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module xpm_source_scanner (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tlast,   // end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // row_byte, row_number, image_width, image_height,
                                        // color_count, chars_per_pixel, zero fill
    output logic [2:0]       m_tuser    // kind
);

    // The parser works on each byte in the cycle it is accepted and drops up to two
    // result words into the queue; the queue registers decouple the two stream sides.
    logic               accept;
    logic               room;
    xss_pkg::push_t     push;
    xss_pkg::result_t   head;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    xss_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .push     (push)
    );

    xss_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    // Output word layout, highest bits first.
    assign m_tdata = {7'd0,
                      head.chars_per_pixel,
                      head.color_count,
                      head.image_height,
                      head.image_width,
                      head.row_number,
                      head.row_byte};
    assign m_tuser = head.kind;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT     = 3_000_000;
    localparam int unsigned BODY_ITEMS      = 1320;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES    = 16;

    // One source byte as it is offered to the scanner. A quiet row is known to give no word.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       quiet;
    } src_item_t;

    // Opening part: comment and string tracking before and around the header.
    localparam src_item_t DIRECTED_ROWS [25] = '{
        '{8'h00,               1'b0, 1'b1},   // lowest byte, nothing comes out before the header
        '{8'hFF,               1'b0, 1'b1},   // highest byte
        '{xss_pkg::CHR_SLASH,  1'b0, 1'b1},
        '{xss_pkg::CHR_STAR,   1'b0, 1'b1},   // slash then star opens a comment
        '{xss_pkg::CHR_RBRACE, 1'b0, 1'b1},   // a closing brace inside a comment is ignored
        '{xss_pkg::CHR_QUOTE,  1'b0, 1'b1},   // nor does a quote open a string there
        '{xss_pkg::CHR_STAR,   1'b0, 1'b1},
        '{xss_pkg::CHR_SLASH,  1'b0, 1'b1},   // star then slash closes the comment
        '{xss_pkg::CHR_SLASH,  1'b0, 1'b1},
        '{8'h78,               1'b0, 1'b1},   // a slash not followed by a star opens nothing
        '{xss_pkg::CHR_QUOTE,  1'b0, 1'b1},
        '{8'h00,               1'b0, 1'b1},
        '{8'hFF,               1'b0, 1'b1},
        '{xss_pkg::CHR_QUOTE,  1'b0, 1'b1},   // a string before the header is skipped
        '{xss_pkg::CHR_LBRACE, 1'b0, 1'b0},   // header opens
        '{xss_pkg::CHR_QUOTE,  1'b0, 1'b0},
        '{xss_pkg::CHR_QUOTE,  1'b0, 1'b0},   // empty string
        '{xss_pkg::CHR_QUOTE,  1'b0, 1'b0},
        '{8'h37,               1'b0, 1'b0},   // a single number, so the values string is dropped
        '{xss_pkg::CHR_SLASH,  1'b0, 1'b0},
        '{xss_pkg::CHR_STAR,   1'b0, 1'b0},   // comment opens inside the string
        '{xss_pkg::CHR_QUOTE,  1'b0, 1'b0},   // quote inside that comment does not close it
        '{xss_pkg::CHR_STAR,   1'b0, 1'b0},
        '{xss_pkg::CHR_SLASH,  1'b0, 1'b0},
        '{xss_pkg::CHR_QUOTE,  1'b0, 1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // data_byte
    logic        s_tlast;    // end_of_input
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;    // row_byte, row_number, image_width, image_height,
                             // color_count, chars_per_pixel, zero fill
    logic [2:0]  m_tuser;    // kind

    src_item_t          src_items [$];
    xss_pkg::result_t   pending_words [$];
    xss_pkg::result_t   step_words [$];
    int unsigned bytes_taken = 0;
    int unsigned words_checked = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // Shadow copy of the scanner state.
    bit                 comment_open = 1'b0;
    bit                 in_string = 1'b0;
    bit                 slash_pending = 1'b0;
    bit                 star_pending = 1'b0;
    xss_pkg::section_t  scan_sec = xss_pkg::SEC_PRE;
    logic [16:0]        rows_done = '0;
    logic [15:0]        hdr_vals [4] = '{default: '0};
    int unsigned        num_acc = 0;
    int unsigned        field_idx = 0;
    int unsigned        str_len = 0;
    bit                 row_has_bytes = 1'b0;
    bit                 digits_seen = 1'b0;
    bit                 scan_over = 1'b0;

    xpm_source_scanner i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    function automatic void emit_word(xss_pkg::kind_t k, logic [7:0] b, logic [16:0] row,
                                      bit with_hdr);
        xss_pkg::result_t w;
        w.kind            = k;
        w.row_byte        = b;
        w.row_number      = row;
        w.image_width     = with_hdr ? hdr_vals[0] : '0;
        w.image_height    = with_hdr ? hdr_vals[1] : '0;
        w.color_count     = with_hdr ? hdr_vals[2] : '0;
        w.chars_per_pixel = with_hdr ? hdr_vals[3] : '0;
        step_words.push_back(w);
    endfunction

    function automatic void end_number();
        if (digits_seen && field_idx < 4)
        begin
            hdr_vals[field_idx] = num_acc[15:0];
            field_idx++;
        end
        num_acc     = 0;
        digits_seen = 1'b0;
    endfunction

    // Advances the shadow state by one source byte and collects the words it gives.
    function automatic void scan_byte(logic [7:0] b, logic last);
        bit          consumed;
        int unsigned v;
        int unsigned row_cap;
        consumed = 1'b0;
        if (scan_over)
            return;

        // Comment markers look one byte back; the second byte of a marker is used up.
        if (slash_pending && b == xss_pkg::CHR_STAR && !comment_open)
        begin
            comment_open = 1'b1;
            consumed     = 1'b1;
        end
        else if (star_pending && b == xss_pkg::CHR_SLASH && comment_open)
        begin
            comment_open = 1'b0;
            consumed     = 1'b1;
        end
        slash_pending = 1'b0;
        star_pending  = 1'b0;
        if (!consumed)
        begin
            if (b == xss_pkg::CHR_SLASH && !comment_open)
                slash_pending = 1'b1;
            if (b == xss_pkg::CHR_STAR && comment_open)
                star_pending = 1'b1;
        end

        if (in_string)
        begin
            if (b == xss_pkg::CHR_QUOTE && !comment_open)
            begin
                in_string = 1'b0;
                if (str_len > 0)
                begin
                    if (scan_sec == xss_pkg::SEC_VALUES)
                    begin
                        end_number();
                        if (field_idx >= 4)
                        begin
                            emit_word(xss_pkg::KIND_HEADER, 8'h00, '0, 1'b1);
                            rows_done = 17'd1;
                            scan_sec  = xss_pkg::SEC_ROWS;
                        end
                    end
                    else if (scan_sec == xss_pkg::SEC_ROWS)
                    begin
                        if (row_has_bytes)
                        begin
                            emit_word(xss_pkg::KIND_ROW_END, 8'h00, rows_done, 1'b0);
                            rows_done = rows_done + 17'd1;
                        end
                        else
                            scan_sec = xss_pkg::SEC_EXTRA;
                    end
                end
            end
            else if (str_len >= xss_pkg::MAX_STRING_BYTES)
            begin
                emit_word(xss_pkg::KIND_TOO_LONG, 8'h00, rows_done, 1'b0);
                scan_over = 1'b1;
                scan_sec  = xss_pkg::SEC_DONE;
                return;
            end
            else
            begin
                str_len++;
                if (scan_sec == xss_pkg::SEC_VALUES)
                begin
                    if (b >= xss_pkg::CHR_ZERO && b <= xss_pkg::CHR_NINE)
                    begin
                        v           = num_acc * 10 + (b - xss_pkg::CHR_ZERO);
                        num_acc     = (v > 65535) ? 65535 : v;
                        digits_seen = 1'b1;
                    end
                    else
                        end_number();
                end
                else if (scan_sec == xss_pkg::SEC_ROWS)
                begin
                    row_cap = hdr_vals[2] + hdr_vals[1] + 1;
                    if (rows_done < row_cap)
                    begin
                        emit_word(xss_pkg::KIND_ROW_BYTE, b, rows_done, 1'b0);
                        row_has_bytes = 1'b1;
                    end
                end
            end
        end
        else if (!consumed && !comment_open)
        begin
            if (b == xss_pkg::CHR_QUOTE)
            begin
                in_string     = 1'b1;
                str_len       = 0;
                row_has_bytes = 1'b0;
                field_idx     = 0;
                num_acc       = 0;
                digits_seen   = 1'b0;
            end
            else if (b == xss_pkg::CHR_LBRACE && scan_sec == xss_pkg::SEC_PRE)
                scan_sec = xss_pkg::SEC_VALUES;
            else if (b == xss_pkg::CHR_RBRACE)
            begin
                emit_word(xss_pkg::KIND_BRACE_END, 8'h00, rows_done, 1'b0);
                scan_over = 1'b1;
                scan_sec  = xss_pkg::SEC_DONE;
                return;
            end
        end

        if (last && !scan_over)
        begin
            emit_word(xss_pkg::KIND_EARLY_END, 8'h00, rows_done, 1'b0);
            scan_over = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Output words are compared first, then the byte taken at the same edge is predicted;
    // a byte's words cannot leave before the following edge.
    always @(posedge clk)
    begin : scoreboard
        xss_pkg::result_t want;
        src_item_t        item;
        if (m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t ns: word with nothing expected, expected none, got kind %0d data %h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("kind",            want.kind,            m_tuser);
                check_field("row_byte",        want.row_byte,        m_tdata[7:0]);
                check_field("row_number",      want.row_number,      m_tdata[24:8]);
                check_field("image_width",     want.image_width,     m_tdata[40:25]);
                check_field("image_height",    want.image_height,    m_tdata[56:41]);
                check_field("color_count",     want.color_count,     m_tdata[72:57]);
                check_field("chars_per_pixel", want.chars_per_pixel, m_tdata[88:73]);
                check_field("zero fill",       0,                    m_tdata[95:89]);
            end
            words_checked++;
        end
        if (s_tvalid && s_tready)
        begin
            item = src_items[bytes_taken];
            bytes_taken++;
            step_words.delete();
            scan_byte(s_tdata, s_tlast);
            if (!item.quiet)
                foreach (step_words[k])
                    pending_words.push_back(step_words[k]);
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_byte(logic [7:0] no_a, logic [7:0] no_b,
                                             logic [7:0] no_c);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == no_a || b == no_b || b == no_c);
        return b;
    endfunction

    function automatic void push_byte(logic [7:0] b, logic last);
        src_items.push_back('{data: b, last: last, quiet: 1'b0});
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b0);
    endfunction

    function automatic string number_gap();
        case ($urandom_range(0, 4))
            0: return " ";
            1: return "  ";
            2: return "\t";
            3: return ", ";
            default: return "x";
        endcase
    endfunction

    // Random header value; wide numbers saturate in the scanner.
    function automatic int unsigned header_value(int unsigned pos);
        case (pos)
            0: return $urandom_range(0, 1) ? $urandom_range(0, 999999) : $urandom_range(1, 64);
            1: return ($urandom_range(0, 9) == 0) ? $urandom_range(65536, 999999)
                                                  : $urandom_range(0, 120);
            2: return $urandom_range(0, 24);
            3: return $urandom_range(1, 3);
            default: return $urandom_range(0, 99999);
        endcase
    endfunction

    // A complete values string has four numbers, sometimes a fifth that is ignored.
    function automatic void push_values(bit complete);
        int unsigned count;
        count = complete ? $urandom_range(4, 5) : $urandom_range(0, 3);
        push_byte(xss_pkg::CHR_QUOTE, 1'b0);
        if ($urandom_range(0, 1) == 1)
            push_text(number_gap());
        for (int unsigned k = 0; k < count; k++)
        begin
            if (k != 0)
                push_text(number_gap());
            push_text($sformatf("%0d", header_value(k)));
        end
        push_byte(xss_pkg::CHR_QUOTE, 1'b0);
    endfunction

    // A closed comment whose body holds no slash, so it cannot end early.
    function automatic void push_comment();
        push_byte(xss_pkg::CHR_SLASH, 1'b0);
        push_byte(xss_pkg::CHR_STAR, 1'b0);
        repeat ($urandom_range(0, 5))
            push_byte(($urandom_range(0, 3) == 0) ? xss_pkg::CHR_QUOTE
                      : pick_byte(xss_pkg::CHR_SLASH, xss_pkg::CHR_SLASH,
                                  xss_pkg::CHR_SLASH), 1'b0);
        push_byte(xss_pkg::CHR_STAR, 1'b0);
        push_byte(xss_pkg::CHR_SLASH, 1'b0);
    endfunction

    // A row string, sometimes empty, sometimes with a comment inside it.
    function automatic void push_row_string();
        int unsigned len;
        int unsigned note_at;
        len     = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
        note_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len) : len + 1;
        push_byte(xss_pkg::CHR_QUOTE, 1'b0);
        for (int unsigned k = 0; k <= len; k++)
        begin
            if (k == note_at)
                push_comment();
            if (k < len)
                push_byte(pick_byte(xss_pkg::CHR_QUOTE, xss_pkg::CHR_SLASH,
                                    xss_pkg::CHR_SLASH), 1'b0);
        end
        push_byte(xss_pkg::CHR_QUOTE, 1'b0);
    endfunction

    function automatic void build_stimulus();
        int unsigned pick;
        foreach (DIRECTED_ROWS[k])
            src_items.push_back(DIRECTED_ROWS[k]);

        // Sometimes a short values string first, which the scanner must drop.
        if ($urandom_range(0, 1) == 1)
            push_values(1'b0);
        if ($urandom_range(0, 1) == 1)
            push_comment();
        push_text(",\n");
        push_values(1'b1);

        while (src_items.size() < $size(DIRECTED_ROWS) + BODY_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                push_row_string();
            else if (pick < 75)
                push_text(($urandom_range(0, 1) == 1) ? ",\n" : " ");
            else if (pick < 85)
                push_comment();
            else
                push_byte(pick_byte(xss_pkg::CHR_QUOTE, xss_pkg::CHR_RBRACE,
                                    xss_pkg::CHR_SLASH), 1'b0);
        end

        // One way to end the scan per run; the simulator seed picks which.
        case ($urandom_range(0, 1))
            0: push_byte(xss_pkg::CHR_RBRACE, 1'b1);
            default:
            begin
                // End of file, often inside an open string so a row byte and the end
                // both come from the last byte.
                if ($urandom_range(0, 1) == 1)
                begin
                    push_byte(xss_pkg::CHR_QUOTE, 1'b0);
                    repeat ($urandom_range(0, 3))
                        push_byte(pick_byte(xss_pkg::CHR_QUOTE, xss_pkg::CHR_SLASH,
                                            xss_pkg::CHR_SLASH), 1'b0);
                end
                push_byte(pick_byte(xss_pkg::CHR_QUOTE, xss_pkg::CHR_RBRACE,
                                    xss_pkg::CHR_SLASH), 1'b1);
            end
        endcase

        // Bytes after the end are ignored until reset.
        push_byte(xss_pkg::CHR_RBRACE, 1'b0);
        push_byte(xss_pkg::CHR_QUOTE, 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b1);
    endfunction

    // ---------------------------------------------------------------- source side

    initial
    begin : source_side
        int unsigned gap;
        bit          steady;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        steady   = 1'b0;
        build_stimulus();
        @(posedge rst_n);
        @(negedge clk);
        for (int i = 0; i < src_items.size(); i++)
        begin
            if (i % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            gap = steady ? 0 : idle_len();
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= src_items[i].data;
            s_tlast  <= src_items[i].last;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            @(negedge clk);
        end
        s_tvalid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // ---------------------------------------------------------------- sink side

    initial
    begin : sink_side
        int unsigned stall_left;
        int unsigned mode_left;
        bit          steady;
        bit          held;
        stall_left = 0;
        mode_left  = 0;
        steady     = 1'b0;
        held       = 1'b0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && words_checked >= 16)
            begin
                // Long hold-off while the source keeps offering bytes: the result queue
                // fills and the scanner has to stall its input.
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    steady    = ($urandom_range(0, 4) == 0);
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                if (!steady && stall_left == 0)
                    stall_left = idle_len();
                if (!steady && stall_left != 0)
                begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

endmodule

// File: filelist.f
design/xss_pkg.sv
design/xss_parser.sv
design/xss_out_queue.sv
design/xpm_source_scanner.sv
tb/tb_top.sv
